// File: rtl/u8cd_pkg.sv
// u8cd_pkg: shared types and constants for the utf-8 code point decoder
// no dependencies; used by u8cd_step, utf8_codepoint_decoder and the testbench
`timescale 1ns / 1ps

package u8cd_pkg;

	localparam int unsigned CP_W = 21;

	// byte classes and masks
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;
	localparam logic [7:0] PAY2_MASK  = 8'h1F;
	localparam logic [7:0] PAY3_MASK  = 8'h0F;
	localparam logic [7:0] PAY4_MASK  = 8'h07;

	localparam logic [2:0] LEN2 = 3'd2;
	localparam logic [2:0] LEN3 = 3'd3;
	localparam logic [2:0] LEN4 = 3'd4;

	// replacement character for malformed bytes
	localparam logic [CP_W-1:0] QMARK = 21'h00003F;

	// sequence being gathered
	typedef struct packed {
		logic [1:0]      pend;
		logic [2:0]      exp_len;
		logic [CP_W-1:0] part;
	} seq_state_t;

	// results caused by one byte: a run of '?' then an optional final result
	typedef struct packed {
		logic [1:0]      qcnt;
		logic            fin_valid;
		logic [CP_W-1:0] fin_cp;
		logic            fin_bad;
	} step_res_t;

endpackage

// File: rtl/u8cd_byte_if.sv
// u8cd_byte_if: valid/ready channel carrying one utf-8 text byte
// no dependencies
`timescale 1ns / 1ps

interface u8cd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

// File: rtl/u8cd_cp_if.sv
// u8cd_cp_if: valid/ready channel carrying one decoded code point
// no dependencies
`timescale 1ns / 1ps

interface u8cd_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] codepoint;
	logic        malformed;
	logic        last;

	modport source (output valid, output codepoint, output malformed, output last, input ready);
	modport sink (input valid, input codepoint, input malformed, input last, output ready);
endinterface

// File: rtl/u8cd_step.sv
// u8cd_step: next-state and result logic for one text byte
// depends on u8cd_pkg
`timescale 1ns / 1ps

module u8cd_step (
	input  logic [7:0]          text_byte,
	input  u8cd_pkg::seq_state_t cur,
	output u8cd_pkg::seq_state_t nxt,
	output u8cd_pkg::step_res_t  res
);
	import u8cd_pkg::*;

	logic            is_cont;
	logic [2:0]      held;
	logic [CP_W-1:0] shifted;
	logic [5:0]      cont_bits;

	assign is_cont   = (text_byte & CONT_MASK) == CONT_CODE;
	assign held      = {1'b0, cur.pend} + 3'd1;
	assign cont_bits = text_byte[5:0];
	assign shifted   = {cur.part[CP_W-7:0], cont_bits};

	always_comb begin
		nxt = '0;
		res = '0;
		if (cur.pend != 2'd0 && is_cont) begin
			// continuation of a held sequence
			if (held >= cur.exp_len) begin
				res.fin_valid = 1'b1;
				res.fin_cp    = shifted;
			end else begin
				nxt.pend    = held[1:0];
				nxt.exp_len = cur.exp_len;
				nxt.part    = shifted;
			end
		end else begin
			// flush held bytes, then treat the byte as a fresh lead
			res.qcnt = cur.pend;
			if (text_byte == 8'h00) begin
				// end of text: nothing more
			end else if (!text_byte[7]) begin
				res.fin_valid = 1'b1;
				res.fin_cp    = {{(CP_W-8){1'b0}}, text_byte};
			end else if ((text_byte & LEAD2_MASK) == LEAD2_CODE) begin
				nxt.pend    = 2'd1;
				nxt.exp_len = LEN2;
				nxt.part    = {{(CP_W-8){1'b0}}, text_byte & PAY2_MASK};
			end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
				nxt.pend    = 2'd1;
				nxt.exp_len = LEN3;
				nxt.part    = {{(CP_W-8){1'b0}}, text_byte & PAY3_MASK};
			end else if ((text_byte & LEAD4_MASK) == LEAD4_CODE) begin
				nxt.pend    = 2'd1;
				nxt.exp_len = LEN4;
				nxt.part    = {{(CP_W-8){1'b0}}, text_byte & PAY4_MASK};
			end else begin
				res.fin_valid = 1'b1;
				res.fin_cp    = QMARK;
				res.fin_bad   = 1'b1;
			end
		end
	end

endmodule

// File: rtl/utf8_codepoint_decoder.sv
// utf8_codepoint_decoder: byte-stream utf-8 to code point converter, top level
// depends on u8cd_pkg, u8cd_byte_if, u8cd_cp_if and u8cd_step
`timescale 1ns / 1ps

// Takes one text byte per transfer and gives decoded code points, one per
// transfer, with last set on the final result of each byte. Sequences of 1 to
// 4 bytes are decoded, overlong forms and values up to 0x1FFFFF included.
// Invalid lead bytes give '?' with malformed set; a broken sequence gives one
// malformed '?' per held byte before the breaking byte is decoded as a lead;
// a zero byte flushes held bytes and gives nothing itself. A byte is taken
// into an input register, decoded combinationally into a result register, and
// the results drain one per cycle while the output is ready. A byte with at
// most one result sustains one byte per cycle while the output is ready; a byte
// with several results holds the result register until its last result is taken,
// so the rate is set by the output transfers.
module utf8_codepoint_decoder (
	input logic        clk,
	input logic        arst_n,
	u8cd_byte_if.sink  text,
	u8cd_cp_if.source  points
);
	import u8cd_pkg::*;

	logic            s1_valid_q;
	logic [7:0]      byte_s1;
	seq_state_t      state_q;
	seq_state_t      state_nxt;
	step_res_t       step_res;
	logic [1:0]      qcnt_q;
	logic            fin_q;
	logic [CP_W-1:0] fin_cp_q;
	logic            fin_bad_q;
	logic            res_busy;
	logic            out_xfer;
	logic            res_done;
	logic            load;

	u8cd_step u_step (
		.text_byte (byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	// output drive: pending '?' run first, then the final result
	assign points.valid     = res_busy;
	assign points.codepoint = (qcnt_q != 2'd0) ? QMARK : fin_cp_q;
	assign points.malformed = (qcnt_q != 2'd0) ? 1'b1 : fin_bad_q;
	assign points.last      = (qcnt_q == 2'd0) || (qcnt_q == 2'd1 && !fin_q);

	// result register handshake
	assign res_busy = (qcnt_q != 2'd0) || fin_q;
	assign out_xfer = points.valid && points.ready;
	assign res_done = out_xfer && points.last;
	assign load     = s1_valid_q && (!res_busy || res_done);
	assign text.ready = !s1_valid_q || load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (text.valid && text.ready) begin
			s1_valid_q <= 1'b1;
		end else if (load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
		end
	end

	// sequence state and result counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			qcnt_q  <= 2'd0;
			fin_q   <= 1'b0;
		end else if (load) begin
			state_q <= state_nxt;
			qcnt_q  <= step_res.qcnt;
			fin_q   <= step_res.fin_valid;
		end else if (out_xfer) begin
			if (qcnt_q != 2'd0) begin
				qcnt_q <= qcnt_q - 2'd1;
			end else begin
				fin_q <= 1'b0;
			end
		end
	end

	// final result payload
	always_ff @(posedge clk) begin
		if (load) begin
			fin_cp_q  <= step_res.fin_cp;
			fin_bad_q <= step_res.fin_bad;
		end
	end

endmodule

// File: tb/tb_utf8_codepoint_decoder.sv
// tb_utf8_codepoint_decoder: self-checking bench for the utf-8 code point decoder
// depends on u8cd_pkg, u8cd_byte_if, u8cd_cp_if and utf8_codepoint_decoder
// directed and random byte streams are checked against a built-in decode predictor
`timescale 1ns / 1ps

module tb_utf8_codepoint_decoder;
	import u8cd_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	localparam int unsigned TAIL_CYCLES     = 8;
	localparam int unsigned BYTES_PER_PHASE = 35;
	localparam int unsigned MAX_SHOWN       = 10;
	localparam int unsigned NUM_PHASES      = 3;
	localparam logic [7:0]  TEXT_END        = 8'h00;
	localparam logic [7:0]  ASCII_MAX       = 8'h7F;

	typedef struct packed {
		logic [CP_W-1:0] codepoint;
		logic            malformed;
		logic            last;
	} cp_result_t;

	logic clk = 1'b0;
	logic arst_n;

	u8cd_byte_if text_ch ();
	u8cd_cp_if   cp_ch ();

	utf8_codepoint_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.points (cp_ch)
	);

	// decoder state mirrored by the predictor
	logic [1:0]      held_cnt;
	logic [2:0]      seq_len;
	logic [CP_W-1:0] seq_bits;

	logic [7:0]  pending_bytes[$];
	cp_result_t  expected_points[$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned idle_cycles;
	int unsigned mismatch_count;
	int unsigned bytes_taken;
	int unsigned points_seen;
	int unsigned malformed_seen;
	int unsigned most_points_per_byte;

	always #1 clk = ~clk;

	// expected code point store
	function automatic void add_point(input logic [CP_W-1:0] cp, input logic bad);
		cp_result_t pt;
		pt.codepoint = cp;
		pt.malformed = bad;
		pt.last      = 1'b0;
		expected_points.push_back(pt);
	endfunction

	function automatic void clear_sequence();
		held_cnt = 2'd0;
		seq_len  = 3'd0;
		seq_bits = '0;
	endfunction

	// byte decoded with nothing held
	function automatic void take_lead(input logic [7:0] b);
		if (b == TEXT_END) begin
		end else if (b <= ASCII_MAX) begin
			add_point(CP_W'(b), 1'b0);
		end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
			held_cnt = 2'd1;
			seq_len  = LEN2;
			seq_bits = CP_W'(b & PAY2_MASK);
		end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
			held_cnt = 2'd1;
			seq_len  = LEN3;
			seq_bits = CP_W'(b & PAY3_MASK);
		end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
			held_cnt = 2'd1;
			seq_len  = LEN4;
			seq_bits = CP_W'(b & PAY4_MASK);
		end else begin
			add_point(QMARK, 1'b1);
		end
	endfunction

	// expected code points for one accepted text byte
	function automatic void decode_byte(input logic [7:0] b);
		int unsigned n_prior;
		int unsigned n_new;
		cp_result_t  tail_pt;
		n_prior = expected_points.size();
		if (held_cnt != 2'd0) begin
			if ((b & CONT_MASK) == CONT_CODE) begin
				seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
				if ({1'b0, held_cnt} + 3'd1 >= seq_len) begin
					add_point(seq_bits, 1'b0);
					clear_sequence();
				end else begin
					held_cnt = held_cnt + 2'd1;
				end
			end else begin
				// broken sequence: one '?' per held byte, then a fresh lead
				for (int i = 0; i < held_cnt; i++)
					add_point(QMARK, 1'b1);
				clear_sequence();
				take_lead(b);
			end
		end else begin
			take_lead(b);
		end
		n_new = expected_points.size() - n_prior;
		if (n_new != 0) begin
			tail_pt = expected_points.pop_back();
			tail_pt.last = 1'b1;
			expected_points.push_back(tail_pt);
		end
		if (n_new > most_points_per_byte)
			most_points_per_byte = n_new;
	endfunction

	// random text: mostly well-formed sequences, some truncated ones and noise
	function automatic void add_random_text(input int unsigned n_bytes);
		int unsigned added;
		int unsigned kind;
		int unsigned seq_n;
		int unsigned cont_n;
		logic [7:0]  b;
		added = 0;
		while (added < n_bytes) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				pending_bytes.push_back(8'($urandom_range(ASCII_MAX, 1)));
				added++;
			end else if (kind < 82) begin
				seq_n = $urandom_range(4, 2);
				case (seq_n)
					2: b = {3'b110, 5'($urandom)};
					3: b = {4'b1110, 4'($urandom)};
					default: b = {5'b11110, 3'($urandom)};
				endcase
				// truncated sequences leave the next byte to break them
				cont_n = (kind < 70) ? seq_n - 1 : $urandom_range(seq_n - 2, 0);
				pending_bytes.push_back(b);
				added++;
				for (int i = 0; i < cont_n; i++) begin
					pending_bytes.push_back({2'b10, 6'($urandom)});
					added++;
				end
			end else if (kind < 95) begin
				b = 8'($urandom);
				pending_bytes.push_back(b);
				if (b != TEXT_END)
					added++;
			end else begin
				pending_bytes.push_back(TEXT_END);
			end
		end
	endfunction

	// text byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ch.valid     <= 1'b0;
			text_ch.text_byte <= '0;
		end else if (!text_ch.valid || text_ch.ready) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				text_ch.valid     <= 1'b1;
				text_ch.text_byte <= pending_bytes.pop_front();
			end else begin
				text_ch.valid     <= 1'b0;
				text_ch.text_byte <= 8'($urandom);
			end
		end
	end

	// code point receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cp_ch.ready <= 1'b0;
		else
			cp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: predict on byte transfer, check on code point transfer
	always @(posedge clk) begin
		cp_result_t want;
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready) begin
				decode_byte(text_ch.text_byte);
				bytes_taken++;
			end
			if (cp_ch.valid && cp_ch.ready) begin
				points_seen++;
				if (cp_ch.malformed)
					malformed_seen++;
				if (expected_points.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_SHOWN)
						$display("unexpected code point: cp=%h malformed=%b last=%b",
							cp_ch.codepoint, cp_ch.malformed, cp_ch.last);
				end else begin
					want = expected_points.pop_front();
					if (cp_ch.codepoint !== want.codepoint || cp_ch.malformed !== want.malformed
						|| cp_ch.last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= MAX_SHOWN)
							$display({"code point mismatch: expected cp=%h malformed=%b ",
								"last=%b, got cp=%h malformed=%b last=%b"},
								want.codepoint, want.malformed, want.last,
								cp_ch.codepoint, cp_ch.malformed, cp_ch.last);
					end
				end
			end
			// watchdog on cycles without any transfer
			if ((text_ch.valid && text_ch.ready) || (cp_ch.valid && cp_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: no transfer for %0d cycles, %0d code points outstanding",
						idle_cycles, expected_points.size());
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		int unsigned send_pct[NUM_PHASES];
		int unsigned recv_pct[NUM_PHASES];
		send_pct = '{32, 85, 0};
		recv_pct = '{85, 32, 0};
		arst_n            = 1'b0;
		send_idle_pct     = send_pct[0];
		recv_idle_pct     = recv_pct[0];
		idle_cycles       = 0;
		mismatch_count    = 0;
		bytes_taken       = 0;
		points_seen       = 0;
		malformed_seen    = 0;
		most_points_per_byte = 0;
		clear_sequence();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: end of text with nothing held, ascii extremes, literal '?'
		pending_bytes = '{8'h00, 8'h01, 8'h7F, 8'h3F};
		// invalid leads
		pending_bytes.push_back(8'h80);
		pending_bytes.push_back(8'hBF);
		pending_bytes.push_back(8'hF8);
		pending_bytes.push_back(8'hFF);
		// overlong 2-byte form and the largest 3-byte and 4-byte values
		pending_bytes.push_back(8'hC0);
		pending_bytes.push_back(8'h80);
		pending_bytes.push_back(8'hEF);
		pending_bytes.push_back(8'hBF);
		pending_bytes.push_back(8'hBF);
		pending_bytes.push_back(8'hF7);
		pending_bytes.push_back(8'hBF);
		pending_bytes.push_back(8'hBF);
		pending_bytes.push_back(8'hBF);
		// three held bytes broken by an invalid lead: four malformed results
		pending_bytes.push_back(8'hF0);
		pending_bytes.push_back(8'h80);
		pending_bytes.push_back(8'h80);
		pending_bytes.push_back(8'hFF);
		// lead broken by a new lead, then flushed by end of text
		pending_bytes.push_back(8'hE1);
		pending_bytes.push_back(8'hC3);
		pending_bytes.push_back(TEXT_END);

		for (int p = 0; p < NUM_PHASES; p++) begin
			send_idle_pct = send_pct[p];
			recv_idle_pct = recv_pct[p];
			add_random_text(BYTES_PER_PHASE);
			while (pending_bytes.size() != 0)
				@(posedge clk);
		end

		while (text_ch.valid || expected_points.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_points.size() != 0)
			mismatch_count++;
		$display("decoded %0d text bytes into %0d code points, %0d of them malformed",
			bytes_taken, points_seen, malformed_seen);
		$display("up to %0d code points per byte, %0d failures", most_points_per_byte,
			mismatch_count);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
